// ----- rtl/wavp_pkg.sv -----
// Shared types and constants for the WAV header stream parser.
`timescale 1ns / 1ps

package wavp_pkg;

  // Tags as they read little-endian from four stream bytes
  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
  localparam logic [31:0] FMT_LEN     = 32'd16;
  localparam logic [31:0] BASE_OFFSET = 32'd36;
  localparam logic [31:0] HDR_LEN     = 32'd8;

  localparam int unsigned FMT_BYTES = 16;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_FMT   = 4'd3,
    PH_FLEN  = 4'd4,
    PH_FBODY = 4'd5,
    PH_ID    = 4'd6,
    PH_CSIZE = 4'd7,
    PH_SKIP  = 4'd8,
    PH_DSIZE = 4'd9,
    PH_DATA  = 4'd10,
    PH_WRONG = 4'd11,
    PH_EOF   = 4'd12,
    PH_DONE  = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_IN_DATA = 3'd1,
    ST_WRONG   = 3'd2,
    ST_EOF     = 3'd3,
    ST_DONE    = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [31:0] riff_size;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sampling_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] audio_len;
  } result_t;

endpackage

// ----- rtl/wavp_if.sv -----
// Stream interfaces for the parser: file bytes in, parse results out.
`timescale 1ns / 1ps

interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       stream_end;

  modport source (output valid, output byte_value, output stream_end, input ready);
  modport sink   (input valid, input byte_value, input stream_end, output ready);
endinterface

interface wavp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [31:0] riff_size;
  logic [15:0] audio_format;
  logic [15:0] num_channels;
  logic [31:0] sampling_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] sample_bits;
  logic [31:0] data_offset;
  logic [31:0] audio_len;

  modport source (
    output valid, output status, output data_valid, output data_byte,
    output riff_size, output audio_format, output num_channels,
    output sampling_rate, output byte_rate, output block_align,
    output sample_bits, output data_offset, output audio_len,
    input ready
  );
  modport sink (
    input valid, input status, input data_valid, input data_byte,
    input riff_size, input audio_format, input num_channels,
    input sampling_rate, input byte_rate, input block_align,
    input sample_bits, input data_offset, input audio_len,
    output ready
  );
endinterface

// ----- rtl/wavp_core.sv -----
// Parser state and per-byte update logic; forms the result for each word.
`timescale 1ns / 1ps

module wavp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       byte_value,
  input  logic             stream_end,
  output wavp_pkg::result_t result
);
  import wavp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [23:0] word_shift, word_shift_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [31:0] riff_size_reg, riff_size_reg_next;
  logic [31:0] data_offset_reg, data_offset_reg_next;
  logic [31:0] audio_len_reg, audio_len_reg_next;
  logic [7:0]  fmt_byte [FMT_BYTES];
  logic [7:0]  fmt_byte_next [FMT_BYTES];

  logic        fmt_we;
  logic        final_phase;
  logic [31:0] word;
  logic        out_valid;
  status_t     status;

  assign final_phase = (phase == PH_WRONG) || (phase == PH_EOF) || (phase == PH_DONE);
  // Word completed by this byte (earlier three bytes sit in word_shift)
  assign word = {byte_value, word_shift};

  // Next-state logic for one byte
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    word_shift_next      = word_shift;
    skip_remaining_next  = skip_remaining;
    data_remaining_next  = data_remaining;
    riff_size_reg_next   = riff_size_reg;
    data_offset_reg_next = data_offset_reg;
    audio_len_reg_next   = audio_len_reg;
    fmt_we               = 1'b0;
    out_valid            = 1'b0;

    if (final_phase) begin
      // sticky: nothing changes
    end else if (stream_end) begin
      phase_next = ((phase == PH_ID) || (phase == PH_SKIP)) ? PH_WRONG : PH_EOF;
    end else begin
      unique case (phase)
        PH_FBODY: begin
          fmt_we = 1'b1;
          if (byte_count == 4'd15) begin
            byte_count_next = 4'd0;
            phase_next      = PH_ID;
          end else begin
            byte_count_next = byte_count + 4'd1;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_remaining - 32'd1;
          if (skip_remaining == 32'd1) begin
            phase_next = PH_ID;
          end
        end
        PH_DATA: begin
          out_valid           = 1'b1;
          data_remaining_next = data_remaining - 32'd1;
          if (data_remaining == 32'd1) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          // little-endian word assembly
          word_shift_next = word[31:8];
          if (byte_count[1:0] == 2'd3) begin
            byte_count_next = 4'd0;
            unique case (phase)
              PH_RIFF:  phase_next = (word == TAG_RIFF) ? PH_RSIZE : PH_WRONG;
              PH_RSIZE: begin
                riff_size_reg_next = word;
                phase_next         = PH_WAVE;
              end
              PH_WAVE:  phase_next = (word == TAG_WAVE) ? PH_FMT : PH_WRONG;
              PH_FMT:   phase_next = (word == TAG_FMT) ? PH_FLEN : PH_WRONG;
              PH_FLEN:  phase_next = (word == FMT_LEN) ? PH_FBODY : PH_WRONG;
              PH_ID: begin
                if (word == TAG_DATA) begin
                  data_offset_reg_next = data_offset_reg + HDR_LEN;
                  phase_next           = PH_DSIZE;
                end else begin
                  phase_next = PH_CSIZE;
                end
              end
              PH_CSIZE: begin
                data_offset_reg_next = data_offset_reg + HDR_LEN + word;
                skip_remaining_next  = word;
                phase_next           = (word != 32'd0) ? PH_SKIP : PH_ID;
              end
              default: begin
                audio_len_reg_next  = word;
                data_remaining_next = word;
                phase_next          = (word != 32'd0) ? PH_DATA : PH_DONE;
              end
            endcase
          end else begin
            byte_count_next = {2'b00, byte_count[1:0] + 2'd1};
          end
        end
      endcase
    end
  end

  // fmt body byte lanes
  always_comb begin
    for (int i = 0; i < FMT_BYTES; i++) begin
      fmt_byte_next[i] = (fmt_we && (byte_count == i[3:0])) ? byte_value : fmt_byte[i];
    end
  end

  // Status from the updated phase
  always_comb begin
    unique case (phase_next)
      PH_DATA:  status = ST_IN_DATA;
      PH_WRONG: status = ST_WRONG;
      PH_EOF:   status = ST_EOF;
      PH_DONE:  status = ST_DONE;
      default:  status = ST_PENDING;
    endcase
  end

  // Result word for this byte
  always_comb begin
    result.status          = status;
    result.data_valid      = out_valid;
    result.data_byte       = out_valid ? byte_value : 8'd0;
    result.riff_size       = riff_size_reg_next;
    result.audio_format    = {fmt_byte_next[1], fmt_byte_next[0]};
    result.num_channels    = {fmt_byte_next[3], fmt_byte_next[2]};
    result.sampling_rate   = {fmt_byte_next[7], fmt_byte_next[6],
                              fmt_byte_next[5], fmt_byte_next[4]};
    result.byte_rate       = {fmt_byte_next[11], fmt_byte_next[10],
                              fmt_byte_next[9], fmt_byte_next[8]};
    result.block_align     = {fmt_byte_next[13], fmt_byte_next[12]};
    result.sample_bits     = {fmt_byte_next[15], fmt_byte_next[14]};
    result.data_offset     = data_offset_reg_next;
    result.audio_len       = audio_len_reg_next;
  end

  // State registers, updated on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF;
      byte_count      <= 4'd0;
      word_shift      <= 24'd0;
      skip_remaining  <= 32'd0;
      data_remaining  <= 32'd0;
      riff_size_reg   <= 32'd0;
      data_offset_reg <= BASE_OFFSET;
      audio_len_reg   <= 32'd0;
      for (int i = 0; i < FMT_BYTES; i++) begin
        fmt_byte[i] <= 8'd0;
      end
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      word_shift      <= word_shift_next;
      skip_remaining  <= skip_remaining_next;
      data_remaining  <= data_remaining_next;
      riff_size_reg   <= riff_size_reg_next;
      data_offset_reg <= data_offset_reg_next;
      audio_len_reg   <= audio_len_reg_next;
      for (int i = 0; i < FMT_BYTES; i++) begin
        fmt_byte[i] <= fmt_byte_next[i];
      end
    end
  end

endmodule

// ----- rtl/wavp_out_reg.sv -----
// Output register holding one result word until the receiver takes it.
`timescale 1ns / 1ps

module wavp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wavp_pkg::result_t load_data,
  input  logic              take,
  output logic              valid,
  output logic              can_load,
  output wavp_pkg::result_t data
);
  import wavp_pkg::*;

  // Room for a new word when empty or when the held word leaves now
  assign can_load = !valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ----- rtl/wav_header_stream_parser.sv -----
// WAV header stream parser: top level.
//
// Takes a WAV file one byte per word on file_bytes and returns exactly one
// result word on parse_result for each byte taken. A word with stream_end
// set marks the end of the stream; its byte is ignored.
// Each result carries the parse status, the audio byte passed through while
// in the data chunk, and the header fields captured so far.
// Latency: a result is valid on parse_result the cycle after its byte is
// taken. Throughput: one byte per cycle unless stalled; the output register
// is the only stage, and the byte state updates in that single step.
// Stall: while a result waits on parse_result with ready low, the input is
// still taken in the cycle that the waiting result leaves; otherwise
// file_bytes.ready stays low.
// Reset: rst (synchronous) returns the parser to expecting the RIFF tag,
// clears captured fields, sets the data offset to 36 and drops any pending
// result. Wrong format, early end and data finished are sticky until reset.
`timescale 1ns / 1ps

module wav_header_stream_parser (
  input  logic              clk,
  input  logic              rst,
  wavp_in_if.sink           file_bytes,
  wavp_out_if.source        parse_result
);
  import wavp_pkg::*;

  logic    accept;
  logic    can_load;
  logic    res_valid;
  result_t core_result;
  result_t res;

  assign file_bytes.ready = can_load;
  assign accept           = file_bytes.valid && can_load;

  wavp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (file_bytes.byte_value),
    .stream_end (file_bytes.stream_end),
    .result     (core_result)
  );

  wavp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (core_result),
    .take      (parse_result.ready),
    .valid     (res_valid),
    .can_load  (can_load),
    .data      (res)
  );

  // Result port
  assign parse_result.valid           = res_valid;
  assign parse_result.status          = res.status;
  assign parse_result.data_valid      = res.data_valid;
  assign parse_result.data_byte       = res.data_byte;
  assign parse_result.riff_size       = res.riff_size;
  assign parse_result.audio_format    = res.audio_format;
  assign parse_result.num_channels    = res.num_channels;
  assign parse_result.sampling_rate   = res.sampling_rate;
  assign parse_result.byte_rate       = res.byte_rate;
  assign parse_result.block_align     = res.block_align;
  assign parse_result.sample_bits     = res.sample_bits;
  assign parse_result.data_offset     = res.data_offset;
  assign parse_result.audio_len       = res.audio_len;

endmodule

// ----- rtl/wavp_checker.sv -----
// Port-level checks on the parser result stream, bound to the top level.
`timescale 1ns / 1ps

module wavp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       data_valid,
  input logic [7:0] data_byte
);
  import wavp_pkg::*;

  // A held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Audio bytes appear only in data or at the data end
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> (status == ST_IN_DATA) || (status == ST_DONE))
    else $error("data byte outside data chunk");

  // No audio byte value without the valid flag
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data_byte == 8'd0)
    else $error("stray data byte");

  // Final status is sticky across back-to-back results
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready &&
    ((status == ST_WRONG) || (status == ST_EOF) || (status == ST_DONE))
    |=> !out_valid || (status == $past(status)))
    else $error("final status changed");

  // No audio byte after a final status
  a_no_data_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && ((status == ST_WRONG) || (status == ST_EOF) ||
    (status == ST_DONE)) |=> !out_valid || !data_valid)
    else $error("data byte after final status");

endmodule

bind wav_header_stream_parser wavp_checker u_wavp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (parse_result.valid),
  .out_ready  (parse_result.ready),
  .status     (parse_result.status),
  .data_valid (parse_result.data_valid),
  .data_byte  (parse_result.data_byte)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the WAV header stream parser: one full file streamed byte by byte.

module tb;
  import wavp_pkg::*;

  logic clk;
  logic rst;

  wavp_in_if  bytes_if ();
  wavp_out_if res_if ();

  wav_header_stream_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .file_bytes   (bytes_if),
    .parse_result (res_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mirror of the parser state
  phase_t      ph;
  logic [4:0]  cnt;
  logic [31:0] shift_word;
  logic [31:0] skip_left;
  logic [31:0] audio_left;
  logic [31:0] riff_sz;
  logic [63:0] fmt_lo;
  logic [63:0] fmt_hi;
  logic [31:0] audio_ofs;
  logic [31:0] audio_sz;

  result_t pending_results[$];
  result_t got;
  result_t want;
  int      mismatches;
  int      n_checked;
  int      n_bytes;
  int      n_audio;
  int      n_chunks;
  int      out_wait;
  bit      quiet;

  function automatic void reset_model();
    ph         = PH_RIFF;
    cnt        = '0;
    shift_word = '0;
    skip_left  = '0;
    audio_left = '0;
    riff_sz    = '0;
    fmt_lo     = '0;
    fmt_hi     = '0;
    audio_ofs  = BASE_OFFSET;
    audio_sz   = '0;
  endfunction

  // A full 4-byte field has been collected
  function automatic void close_word(logic [31:0] w);
    case (ph)
      PH_RIFF:  ph = (w == TAG_RIFF) ? PH_RSIZE : PH_WRONG;
      PH_RSIZE: begin
        riff_sz = w;
        ph      = PH_WAVE;
      end
      PH_WAVE:  ph = (w == TAG_WAVE) ? PH_FMT : PH_WRONG;
      PH_FMT:   ph = (w == TAG_FMT) ? PH_FLEN : PH_WRONG;
      PH_FLEN:  ph = (w == FMT_LEN) ? PH_FBODY : PH_WRONG;
      PH_ID: begin
        if (w == TAG_DATA) begin
          audio_ofs = audio_ofs + HDR_LEN;
          ph        = PH_DSIZE;
        end else begin
          ph = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        audio_ofs = audio_ofs + HDR_LEN + w;
        skip_left = w;
        ph        = (w != 0) ? PH_SKIP : PH_ID;
      end
      default: begin
        audio_sz   = w;
        audio_left = w;
        ph         = (w != 0) ? PH_DATA : PH_DONE;
      end
    endcase
  endfunction

  // Advance the mirror by one accepted byte and build the result it causes
  function automatic result_t predict_parse(logic [7:0] b, logic ended);
    result_t    r;
    logic [3:0] idx;
    r = '0;
    if (ph >= PH_WRONG) begin
      // final states hold
    end else if (ended) begin
      ph = (ph == PH_ID || ph == PH_SKIP) ? PH_WRONG : PH_EOF;
    end else if (ph == PH_FBODY) begin
      idx = cnt[3:0];
      if (idx < 8) fmt_lo[8*idx[2:0] +: 8] = fmt_lo[8*idx[2:0] +: 8] | b;
      else         fmt_hi[8*idx[2:0] +: 8] = fmt_hi[8*idx[2:0] +: 8] | b;
      cnt = {1'b0, idx} + 5'd1;
      if (cnt >= 5'd16) begin
        cnt = '0;
        ph  = PH_ID;
      end
    end else if (ph == PH_SKIP) begin
      skip_left = skip_left - 1;
      if (skip_left == 0) ph = PH_ID;
    end else if (ph == PH_DATA) begin
      r.data_valid = 1'b1;
      r.data_byte  = b;
      audio_left   = audio_left - 1;
      if (audio_left == 0) ph = PH_DONE;
    end else begin
      shift_word = {b, shift_word[31:8]};
      cnt        = {3'b000, cnt[1:0]} + 5'd1;
      if (cnt >= 5'd4) begin
        cnt = '0;
        close_word(shift_word);
      end
    end

    if (ph < PH_DATA)        r.status = ST_PENDING;
    else if (ph == PH_DATA)  r.status = ST_IN_DATA;
    else if (ph == PH_WRONG) r.status = ST_WRONG;
    else if (ph == PH_EOF)   r.status = ST_EOF;
    else                     r.status = ST_DONE;

    r.riff_size       = riff_sz;
    r.audio_format    = fmt_lo[15:0];
    r.num_channels    = fmt_lo[31:16];
    r.sampling_rate   = fmt_lo[63:32];
    r.byte_rate       = fmt_hi[31:0];
    r.block_align     = fmt_hi[47:32];
    r.sample_bits     = fmt_hi[63:48];
    r.data_offset     = audio_ofs;
    r.audio_len       = audio_sz;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, fname, e, a);
    end
  endfunction

  // Result side: per-word stall drawn at random, none while quiet
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      out_wait     = 0;
    end else if (res_if.valid && res_if.ready) begin
      out_wait     = quiet ? 0 : $urandom_range(0, 4);
      res_if.ready <= (out_wait == 0);
    end else if (out_wait > 0) begin
      res_if.ready <= (out_wait == 1);
      out_wait     = out_wait - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      got.status          = status_t'(res_if.status);
      got.data_valid      = res_if.data_valid;
      got.data_byte       = res_if.data_byte;
      got.riff_size       = res_if.riff_size;
      got.audio_format    = res_if.audio_format;
      got.num_channels    = res_if.num_channels;
      got.sampling_rate   = res_if.sampling_rate;
      got.byte_rate       = res_if.byte_rate;
      got.block_align     = res_if.block_align;
      got.sample_bits     = res_if.sample_bits;
      got.data_offset     = res_if.data_offset;
      got.audio_len       = res_if.audio_len;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word with nothing predicted", $realtime);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
        check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
        check_field("riff_size", want.riff_size, got.riff_size);
        check_field("audio_format", 32'(want.audio_format), 32'(got.audio_format));
        check_field("num_channels", 32'(want.num_channels), 32'(got.num_channels));
        check_field("sampling_rate", want.sampling_rate, got.sampling_rate);
        check_field("byte_rate", want.byte_rate, got.byte_rate);
        check_field("block_align", 32'(want.block_align), 32'(got.block_align));
        check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
        check_field("data_offset", want.data_offset, got.data_offset);
        check_field("audio_len", want.audio_len, got.audio_len);
      end
    end
  end

  // Send one byte word; the sender gap is drawn per word
  task automatic send_byte(input logic [7:0] b, input logic ended = 1'b0);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_if.valid      <= 1'b1;
    bytes_if.byte_value <= b;
    bytes_if.stream_end <= ended;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    pending_results.push_back(predict_parse(b, ended));
    n_bytes++;
  endtask

  // Little-endian field of nbytes
  task automatic send_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) send_byte(v[8*i +: 8]);
  endtask

  task automatic wait_results_drained();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Non-data chunk with a random id and random body
  task automatic skip_chunk(input int unsigned size);
    logic [31:0] id;
    id = $urandom;
    while (id == TAG_DATA) id = $urandom;
    send_le(id, 4);
    send_le(size, 4);
    repeat (size) send_byte(8'($urandom));
    n_chunks++;
  endtask

  // RIFF/WAVE/fmt header with extreme field values
  task automatic test_header();
    quiet = 1'b0;
    send_le(TAG_RIFF, 4);
    send_le(32'hFFFF_FFFF, 4);
    send_le(TAG_WAVE, 4);
    send_le(TAG_FMT, 4);
    send_le(FMT_LEN, 4);
    send_le(32'h0000_FFFF, 2);
    send_le(32'h0000_0000, 2);
    send_le(32'hFFFF_FFFF, 4);
    send_le(32'h0000_0000, 4);
    send_le(32'h0000_FFFF, 2);
    send_le(32'h0000_0000, 2);
  endtask

  // Empty chunk goes straight to the next id; one-byte chunk skips once
  task automatic test_chunk_edges();
    skip_chunk(0);
    skip_chunk(1);
  endtask

  task automatic test_random_chunks();
    repeat ($urandom_range(6, 10)) begin
      quiet = ($urandom_range(0, 3) == 0);
      skip_chunk($urandom_range(0, 40));
    end
    quiet = 1'b0;
  endtask

  // Data chunk: byte extremes first, then random audio with idle stretches switched
  task automatic test_audio_data();
    int unsigned len;
    len = $urandom_range(600, 700);
    send_le(TAG_DATA, 4);
    send_le(len, 4);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    n_audio += 4;
    for (int unsigned i = 4; i < len; i++) begin
      if (i % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_byte(8'($urandom));
      n_audio++;
    end
    quiet = 1'b0;
  endtask

  // After data end everything is ignored, stream end included
  task automatic test_after_finish();
    send_byte(8'hFF, 1'b1);
    repeat (10) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst                 = 1'b1;
    bytes_if.valid      = 1'b0;
    bytes_if.byte_value = 8'h00;
    bytes_if.stream_end = 1'b0;
    res_if.ready        = 1'b0;
    quiet               = 1'b0;
    mismatches          = 0;
    n_checked           = 0;
    n_bytes             = 0;
    n_audio             = 0;
    n_chunks            = 0;
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header();
    test_chunk_edges();
    // hold the sender until every result is back
    wait_results_drained();
    test_random_chunks();
    test_audio_data();
    test_after_finish();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", pending_results.size());
    end

    $display("Streamed %0d file bytes: header, %0d skipped chunks, %0d audio bytes, tail after end",
             n_bytes, n_chunks, n_audio);
    $display("Compared %0d result words, %0d field mismatches", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
